FILE: hw/rtl/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared types and constants of the sliding-window byte-rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = 38;
  localparam int TOTAL_W       = 64;
  localparam int TIME_W        = 32;
  localparam int BYTES_W       = 32;
  localparam int WIN_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int REC_W         = TIME_W + BYTES_W;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_RECORD = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]         action;
    logic [BYTES_W-1:0] byte_count;
  } item_t;

  typedef struct packed {
    logic               may_send;
    logic               limit_exceeded;
    logic               throttling;
    logic               throttle_changed;
    logic [SUM_W-1:0]   window_bytes;
    logic [TOTAL_W-1:0] total_bytes;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_APPEND,
    ST_PRUNE_WAIT,
    ST_PRUNE_CHK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic tick;
    logic clear;
    logic set_may;
    logic add_total;
    logic drop;
    logic append;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic limit_on;
    logic ring_full;
    logic expired;
    logic is_query;
  } status_t;

endpackage

FILE: hw/rtl/swrl_ram.sv
// ----------------------------------------------------------------------------
// swrl_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module swrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/swrl_ctrl.sv
// ----------------------------------------------------------------------------
// swrl_ctrl
// Sequencer of the rate limiter: decodes items and steps the prune loop.
// ----------------------------------------------------------------------------
module swrl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       action,
  input  swrl_pkg::status_t status,
  output swrl_pkg::cmd_t   cmd,
  output logic             busy
);
  import swrl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_QUERY:  state_next = status.limit_on ? ST_PRUNE_CHK : ST_FINISH;
            ACT_RECORD: state_next = status.ring_full ? ST_DROP : ST_APPEND;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_DROP:       state_next = ST_APPEND;
      ST_APPEND:     state_next = ST_PRUNE_WAIT;
      ST_PRUNE_WAIT: state_next = ST_PRUNE_CHK;
      ST_PRUNE_CHK:  state_next = status.expired ? ST_PRUNE_WAIT : ST_FINISH;
      ST_FINISH:     state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
        if (start) begin
          case (action)
            ACT_TICK:   cmd.tick      = 1'b1;
            ACT_QUERY:  cmd.set_may   = !status.limit_on;
            ACT_RECORD: cmd.add_total = 1'b1;
            ACT_CLEAR:  cmd.clear     = 1'b1;
            default:    cmd.tick      = 1'b0;
          endcase
        end
      end
      ST_DROP:   cmd.drop   = 1'b1;
      ST_APPEND: cmd.append = 1'b1;
      ST_PRUNE_CHK: begin
        cmd.drop   = status.expired;
        cmd.decide = !status.expired && status.is_query;
      end
      ST_FINISH: cmd.finish = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/swrl_datapath.sv
// ----------------------------------------------------------------------------
// swrl_datapath
// Time counter, record ring, window sum, grand total, throttle flag and
// configuration registers of the rate limiter.
// ----------------------------------------------------------------------------
module swrl_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  swrl_pkg::item_t                    item,
  input  swrl_pkg::cmd_t                     cmd,
  output swrl_pkg::status_t                  status,
  input  logic                               cfg_write,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output swrl_pkg::result_t                  result,
  output logic                               done
);
  import swrl_pkg::*;

  logic [BYTES_W-1:0] limit_bytes;
  logic               limit_enable;
  logic [WIN_W-1:0]   window_ms;

  logic [TIME_W-1:0]  time_now;
  logic [IDX_W-1:0]   ring_head;
  logic [CNT_W-1:0]   ring_count;
  logic [SUM_W-1:0]   window_sum;
  logic [TOTAL_W-1:0] grand_total;
  logic               throttle_flag;
  logic               flag_before;
  logic               may_q;
  logic               refused_q;
  logic               query_q;
  logic [BYTES_W-1:0] bytes_q;

  logic [REC_W-1:0]   rec_rdata;
  logic [TIME_W-1:0]  rec_time;
  logic [BYTES_W-1:0] rec_bytes;
  logic [TIME_W-1:0]  age;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   head_inc;
  logic [SUM_W:0]     demand;
  logic               fits;

  swrl_ram #(
    .WIDTH(REC_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.append),
    .waddr(slot),
    .wdata({time_now, bytes_q}),
    .raddr(ring_head),
    .rdata(rec_rdata)
  );

  assign rec_time  = rec_rdata[REC_W-1:BYTES_W];
  assign rec_bytes = rec_rdata[BYTES_W-1:0];
  assign age       = time_now - rec_time;

  assign slot_sum = {1'b0, ring_head} + {1'b0, ring_count[IDX_W-1:0]};
  assign slot     = (slot_sum >= (IDX_W+1)'(HISTORY_DEPTH))
                  ? IDX_W'(slot_sum - (IDX_W+1)'(HISTORY_DEPTH))
                  : slot_sum[IDX_W-1:0];
  assign head_inc = (ring_head == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : ring_head + 1'b1;

  assign demand = {1'b0, window_sum} + (SUM_W+1)'(bytes_q);
  assign fits   = demand <= (SUM_W+1)'(limit_bytes);

  assign status.limit_on  = limit_enable && (limit_bytes != '0);
  assign status.ring_full = ring_count == CNT_W'(HISTORY_DEPTH);
  assign status.expired   = (ring_count != '0) && (age > TIME_W'(window_ms));
  assign status.is_query  = query_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_bytes  <= '0;
      limit_enable <= 1'b0;
      window_ms    <= WINDOW_MS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LIMIT_BYTES:  limit_bytes  <= cfg_data;
        CFG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        CFG_WINDOW_MS:    window_ms    <= cfg_data[WIN_W-1:0];
        default:          limit_enable <= limit_enable;
      endcase
    end
  end

  // ring and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now      <= '0;
      ring_head     <= '0;
      ring_count    <= '0;
      window_sum    <= '0;
      grand_total   <= '0;
      throttle_flag <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear) begin
        time_now      <= '0;
        ring_head     <= '0;
        ring_count    <= '0;
        window_sum    <= '0;
        grand_total   <= '0;
        throttle_flag <= 1'b0;
      end else begin
        if (cmd.tick) begin
          time_now <= time_now + 1'b1;
        end
        if (cmd.add_total) begin
          grand_total <= grand_total + TOTAL_W'(item.byte_count);
        end
        if (cmd.drop) begin
          window_sum <= window_sum - SUM_W'(rec_bytes);
          ring_head  <= head_inc;
          ring_count <= ring_count - 1'b1;
        end else if (cmd.append) begin
          window_sum <= window_sum + SUM_W'(bytes_q);
          ring_count <= ring_count + 1'b1;
        end
        if (cmd.decide) begin
          throttle_flag <= !fits;
        end
      end
    end
  end

  // per-item scratch and result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      bytes_q     <= item.byte_count;
      query_q     <= item.action == ACT_QUERY;
      flag_before <= throttle_flag;
      may_q       <= cmd.set_may;
      refused_q   <= 1'b0;
    end
    if (cmd.decide) begin
      may_q     <= fits;
      refused_q <= !fits;
    end
    if (cmd.finish) begin
      result.may_send         <= may_q;
      result.limit_exceeded   <= refused_q;
      result.throttling       <= throttle_flag;
      result.throttle_changed <= throttle_flag != flag_before;
      result.window_bytes     <= window_sum;
      result.total_bytes      <= grand_total;
    end
  end

endmodule

FILE: hw/rtl/sliding_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding-window byte-rate limiter with a ring of transfer records.
// ----------------------------------------------------------------------------
// busy is high while an item is worked: tick, reset and unlimited query items
// finish directly, a limited query runs the prune check and a record appends
// (dropping the oldest when the ring is full) and prunes; each pruned record
// costs one history read and one check. done pulses in the cycle busy falls;
// the next item may start then. The result is shown for one cycle and cannot
// be stalled. rst clears control, ring, sums, flag, config; history needs none.
module sliding_window_rate_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  swrl_pkg::item_t                 item,
  output swrl_pkg::result_t               result,
  output logic                            done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swrl_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  swrl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(item.action),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  swrl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd      (cmd),
    .status   (status),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result),
    .done     (done)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_answer_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.may_send && result.limit_exceeded))
    else $error("query both allowed and refused");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.drop, cmd.append, cmd.decide, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window byte-rate limiter. A directed
// table hits the extremes, every action and the odd register cases, then
// random traffic runs under several limit settings and idle patterns. Every
// result is compared field by field against its typed row or the ring model.
// ----------------------------------------------------------------------------
module tb_top;
  import swrl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  code;
    logic [31:0] value;
    result_t     want;
  } row_t;

  localparam result_t NO_RESULT = '0;
  localparam int NUM_ROWS = 38;

  // typed results only for the rows that read off at a glance
  localparam row_t PLAN [NUM_ROWS] = '{
    '{ROW_CHECKED, ACT_QUERY,  32'h0, '{1'b1, 1'b0, 1'b0, 1'b0, 38'h0, 64'h0}},
    '{ROW_CHECKED, ACT_RECORD, 32'hFFFF_FFFF,
      '{1'b0, 1'b0, 1'b0, 1'b0, 38'hFFFF_FFFF, 64'hFFFF_FFFF}},
    '{ROW_CHECKED, ACT_RECORD, 32'hFFFF_FFFF,
      '{1'b0, 1'b0, 1'b0, 1'b0, 38'h1_FFFF_FFFE, 64'h1_FFFF_FFFE}},
    '{ROW_CHECKED, ACT_TICK,   32'h0,
      '{1'b0, 1'b0, 1'b0, 1'b0, 38'h1_FFFF_FFFE, 64'h1_FFFF_FFFE}},
    '{ROW_CHECKED, ACT_QUERY,  32'hFFFF_FFFF,
      '{1'b1, 1'b0, 1'b0, 1'b0, 38'h1_FFFF_FFFE, 64'h1_FFFF_FFFE}},
    '{ROW_CHECKED, ACT_CLEAR,  32'h0, '{1'b0, 1'b0, 1'b0, 1'b0, 38'h0, 64'h0}},
    '{ROW_CFG,  CFG_LIMIT_BYTES,  32'd100, NO_RESULT},
    '{ROW_CFG,  CFG_LIMIT_ENABLE, 32'd1,   NO_RESULT},
    '{ROW_CFG,  CFG_WINDOW_MS,    32'd3,   NO_RESULT},
    '{ROW_ITEM, ACT_RECORD, 32'd60,  NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd40,  NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd41,  NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd41,  NO_RESULT},
    '{ROW_ITEM, ACT_TICK,   32'd0,   NO_RESULT},
    '{ROW_ITEM, ACT_TICK,   32'd0,   NO_RESULT},
    '{ROW_ITEM, ACT_TICK,   32'd0,   NO_RESULT},
    '{ROW_ITEM, ACT_TICK,   32'd0,   NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd100, NO_RESULT},
    '{ROW_ITEM, ACT_RECORD, 32'd30,  NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CHECKED, ACT_CLEAR, 32'h0, '{1'b0, 1'b0, 1'b0, 1'b1, 38'h0, 64'h0}},
    '{ROW_CFG,  CFG_WINDOW_MS,    32'h0001_0000, NO_RESULT},
    '{ROW_ITEM, ACT_RECORD, 32'd5, NO_RESULT},
    '{ROW_ITEM, ACT_TICK,   32'd0, NO_RESULT},
    '{ROW_ITEM, ACT_RECORD, 32'd7, NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd0, NO_RESULT},
    '{ROW_CFG,  CFG_LIMIT_ENABLE, 32'hFFFF_FFFE, NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CFG,  CFG_UNUSED,       32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CFG,  CFG_LIMIT_ENABLE, 32'd1, NO_RESULT},
    '{ROW_CFG,  CFG_LIMIT_BYTES,  32'd0, NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CHECKED, ACT_CLEAR, 32'h0, '{1'b0, 1'b0, 1'b0, 1'b0, 38'h0, 64'h0}},
    '{ROW_CFG,  CFG_LIMIT_BYTES,  32'hFFFF_FFFF, NO_RESULT},
    '{ROW_CFG,  CFG_WINDOW_MS,    32'h0000_FFFF, NO_RESULT},
    '{ROW_ITEM, ACT_RECORD, 32'hFFFF_FFFF, NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd0, NO_RESULT},
    '{ROW_ITEM, ACT_QUERY,  32'd1, NO_RESULT}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_t                 item;
  result_t               result;
  logic                  done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model of the limiter
  logic [31:0]        lim_bytes;
  logic               lim_en;
  logic [WIN_W-1:0]   win_ms;
  logic [31:0]        now_ms;
  logic [31:0]        stamp_mem [HISTORY_DEPTH];
  logic [31:0]        size_mem [HISTORY_DEPTH];
  logic [IDX_W-1:0]   ring_rd;
  logic [CNT_W-1:0]   ring_fill;
  logic [SUM_W-1:0]   win_sum;
  logic [TOTAL_W-1:0] grand_sum;
  logic               throttled;

  result_t pending_results [$];
  result_t want_r;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int refusals = 0;
  int flips = 0;
  int overflows = 0;
  int calm_left = 0;
  int ticks_left = 0;
  int tick_pct;
  int rec_pct;
  bit clear_ok;

  always #10 clk = ~clk;

  sliding_window_rate_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .result    (result),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void clear_history();
    now_ms    = '0;
    ring_rd   = '0;
    ring_fill = '0;
    win_sum   = '0;
    grand_sum = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      stamp_mem[i] = '0;
      size_mem[i]  = '0;
    end
  endfunction

  function automatic void retire_oldest();
    win_sum   = win_sum - SUM_W'(size_mem[ring_rd]);
    ring_rd   = ring_rd + 1'b1;
    ring_fill = ring_fill - 1'b1;
  endfunction

  function automatic void expire_stale();
    while (ring_fill != 0 && (now_ms - stamp_mem[ring_rd]) > 32'(win_ms))
      retire_oldest();
  endfunction

  function automatic result_t predict_item(item_t it);
    result_t          r;
    logic             was;
    logic [63:0]      need;
    logic [IDX_W-1:0] slot;
    r   = '0;
    was = throttled;
    case (it.action)
      ACT_TICK: begin
        now_ms = now_ms + 1;
      end
      ACT_QUERY: begin
        if (!lim_en || lim_bytes == 0) begin
          r.may_send = 1'b1;
        end else begin
          expire_stale();
          need = 64'(win_sum) + 64'(it.byte_count);
          if (need <= 64'(lim_bytes)) begin
            r.may_send = 1'b1;
            throttled  = 1'b0;
          end else begin
            r.limit_exceeded = 1'b1;
            throttled        = 1'b1;
            refusals++;
          end
        end
      end
      ACT_RECORD: begin
        grand_sum = grand_sum + 64'(it.byte_count);
        if (ring_fill >= HISTORY_DEPTH) begin
          retire_oldest();
          overflows++;
        end
        slot            = ring_rd + ring_fill[IDX_W-1:0];
        stamp_mem[slot] = now_ms;
        size_mem[slot]  = it.byte_count;
        ring_fill       = ring_fill + 1'b1;
        win_sum         = win_sum + SUM_W'(it.byte_count);
        expire_stale();
      end
      default: begin
        clear_history();
        throttled = 1'b0;
      end
    endcase
    r.throttling       = throttled;
    r.throttle_changed = (throttled != was);
    if (r.throttle_changed) flips++;
    r.window_bytes = win_sum;
    r.total_bytes  = grand_sum;
    return r;
  endfunction

  function automatic int pick_gap(int mode);
    int g;
    int pct;
    g = 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 20);
      return 0;
    end
    pct = (mode == 1) ? 71 : (mode == 3) ? 34 : 0;
    while (g < 30 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected result, expected none, actual %p", $time, result);
      end else begin
        want_r = pending_results.pop_front();
        compare_field("may_send", 64'(want_r.may_send), 64'(result.may_send));
        compare_field("limit_exceeded", 64'(want_r.limit_exceeded),
                      64'(result.limit_exceeded));
        compare_field("throttling", 64'(want_r.throttling), 64'(result.throttling));
        compare_field("throttle_changed", 64'(want_r.throttle_changed),
                      64'(result.throttle_changed));
        compare_field("window_bytes", 64'(want_r.window_bytes), 64'(result.window_bytes));
        compare_field("total_bytes", want_r.total_bytes, result.total_bytes);
        results_checked++;
      end
    end
  end

  task automatic send_item(input item_t it, input int gap_after, input bit use_typed,
                           input result_t typed);
    result_t predicted;
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    predicted = predict_item(it);
    pending_results.push_back(use_typed ? typed : predicted);
    items_sent++;
    if (gap_after > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap_after - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LIMIT_BYTES:  lim_bytes = data;
      CFG_LIMIT_ENABLE: lim_en    = data[0];
      CFG_WINDOW_MS:    win_ms    = data[WIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_item(output item_t it);
    int          r;
    int          s;
    logic [31:0] scale;
    logic [63:0] room;
    it.byte_count = $urandom;
    if (ticks_left > 0) begin
      ticks_left--;
      it.action = ACT_TICK;
      return;
    end
    r     = $urandom_range(0, 99);
    s     = $urandom_range(0, 19);
    scale = (lim_bytes >> 3) | 32'd3;
    if (r < tick_pct) begin
      it.action  = ACT_TICK;
      ticks_left = $urandom_range(0, 3);
    end else if (r < tick_pct + rec_pct) begin
      it.action = ACT_RECORD;
      if (s == 1)
        it.byte_count = s[0] ? '1 : '0;
      else if (s == 2)
        it.byte_count = '1;
      else if (s > 2)
        it.byte_count = $urandom_range(0, scale);
    end else if (r < 98 || !clear_ok) begin
      it.action = ACT_QUERY;
      room = (64'(lim_bytes) > 64'(win_sum)) ? 64'(lim_bytes) - 64'(win_sum) : 64'd0;
      if (s < 7)
        it.byte_count = 32'(room) + 32'($urandom_range(0, 4)) - 32'd2;
      else if (s < 13)
        it.byte_count = $urandom_range(0, scale << 1);
      else if (s >= 17)
        it.byte_count = s[0] ? '1 : '0;
    end else begin
      it.action = ACT_CLEAR;
    end
  endtask

  initial begin
    item_t       it;
    int          gap;
    int          budget;
    logic [31:0] set_lim;
    logic [31:0] set_en;
    logic [31:0] set_win;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    lim_bytes = '0;
    lim_en    = 1'b0;
    win_ms    = WINDOW_MS_RESET;
    throttled = 1'b0;
    clear_history();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_reg(PLAN[i].code, PLAN[i].value);
      end else begin
        it.action     = PLAN[i].code;
        it.byte_count = PLAN[i].value;
        gap = (i + 1 == NUM_ROWS || PLAN[i + 1].kind == ROW_CFG) ? 1 : $urandom_range(0, 2);
        send_item(it, gap, PLAN[i].kind == ROW_CHECKED, PLAN[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      budget   = 66;
      tick_pct = 30;
      rec_pct  = 35;
      clear_ok = 1'b1;
      set_en   = 32'd1;
      case (p)
        0: begin
          set_lim = 32'd1000;
          set_win = 32'd10;
        end
        1: begin
          // wide window, record heavy: the ring fills and wraps
          set_lim  = 32'hFFFF_FFFF;
          set_win  = 32'hFFFF;
          budget   = 90;
          tick_pct = 3;
          rec_pct  = 85;
          clear_ok = 1'b0;
        end
        2: begin
          set_lim = 32'd5000;
          set_win = 32'd1;
        end
        3: begin
          set_lim  = 32'd200;
          set_en   = 32'd0;
          set_win  = 32'd20;
          tick_pct = 25;
          rec_pct  = 40;
        end
        4: begin
          set_lim = $urandom;
          set_win = $urandom_range(1, 40);
        end
        5: begin
          set_lim = 32'd1;
          set_win = 32'd3;
        end
        6: begin
          set_lim  = 32'd300000;
          set_win  = 32'd100;
          tick_pct = 20;
          rec_pct  = 45;
        end
        default: begin
          set_lim = $urandom;
          set_en  = $urandom_range(0, 1);
          set_win = $urandom_range(1, 200);
        end
      endcase
      write_reg(CFG_LIMIT_BYTES, set_lim);
      write_reg(CFG_LIMIT_ENABLE, set_en);
      write_reg(CFG_WINDOW_MS, set_win);
      ticks_left = 0;
      for (int n = 0; n < budget; n++) begin
        pick_item(it);
        gap = (n + 1 == budget) ? 1 : pick_gap(p % 4);
        send_item(it, gap, 1'b0, NO_RESULT);
      end
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d items over %0d register writes, %0d results compared", items_sent,
             reg_writes, results_checked);
    $display("%0d refused queries, %0d throttle flips, %0d ring overflows", refusals, flips,
             overflows);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
